[design/smbtp_pkg.sv]
// shared types and constants for the smoothstep blended trajectory point unit
// no dependencies

package smbtp_pkg;

    typedef logic signed [31:0] t_sword;
    typedef logic [30:0]        t_uword31;

    localparam int FRAC_BITS_DEF       = 16;
    localparam int MIN_SPEED_SHIFT_DEF = 24;

    // divider pipeline: operand stage, 32 quotient bit stages, sign fix stage
    localparam int DIV_LAT = 34;

    localparam t_uword31 ALPHA_RESET = 31'd65536;

endpackage

[design/smbtp_div.sv]
// pipelined signed by positive divider, truncating toward zero, one quotient bit per stage
// depends on smbtp_pkg

module smbtp_div (
    input  logic               i_clk,
    input  smbtp_pkg::t_sword   i_num,
    input  smbtp_pkg::t_uword31 i_den,
    output smbtp_pkg::t_sword   o_quo
);
    import smbtp_pkg::*;

    localparam int NSTEP = 32;

    logic [30:0] r_rem [0:NSTEP];
    logic [31:0] r_num [0:NSTEP];
    logic [30:0] r_den [0:NSTEP];
    logic        r_neg [0:NSTEP];
    t_sword      r_quo;

    logic [31:0] w_trial [0:NSTEP-1];
    logic        w_ge    [0:NSTEP-1];

    always_comb begin
        for (int k = 0; k < NSTEP; k++) begin
            w_trial[k] = {r_rem[k], r_num[k][31]};
            w_ge[k]    = w_trial[k] >= {1'b0, r_den[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem[0] <= '0;
        r_num[0] <= i_num[31] ? 32'(-i_num) : 32'(i_num);
        r_den[0] <= i_den;
        r_neg[0] <= i_num[31];
        for (int k = 0; k < NSTEP; k++) begin
            if (w_ge[k]) begin
                r_rem[k+1] <= 31'(w_trial[k] - {1'b0, r_den[k]});
            end else begin
                r_rem[k+1] <= w_trial[k][30:0];
            end
            r_num[k+1] <= {r_num[k][30:0], w_ge[k]};
            r_den[k+1] <= r_den[k];
            r_neg[k+1] <= r_neg[k];
        end
        r_quo <= r_neg[NSTEP] ? -$signed(r_num[NSTEP]) : $signed(r_num[NSTEP]);
    end

    assign o_quo = r_quo;

endmodule

[design/smoothstep_blended_trajectory_point_unit.sv]
// top level of the smoothstep blended trajectory point unit
// depends on smbtp_pkg and smbtp_div
//
// usage
//   an item is taken at a rising edge with start high and busy low; busy is
//   always low, so one item may be started in every cycle
//   each item returns one position on o_position with o_valid high for one
//   cycle, in start order
//   the path runs through two passes of 34-stage one-bit-per-stage dividers
//   (duration divisions, then blend window and smoothstep argument
//   divisions) plus twelve capture, multiply and select stages
//   throughput is one item per cycle
//   the receiver cannot stall; every result is a transfer in its one cycle
//   blend_alpha is written over the cfg channel (o_cfg_ready always high);
//   the user must write it only while no item is in flight, which the block
//   does not enforce; a value of zero acts as one; reset clears all valid
//   bits and sets blend_alpha to 65536; items in flight at reset are dropped

module smoothstep_blended_trajectory_point_unit #(
    parameter int FRAC_BITS       = smbtp_pkg::FRAC_BITS_DEF,
    parameter int MIN_SPEED_SHIFT = smbtp_pkg::MIN_SPEED_SHIFT_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  smbtp_pkg::t_sword   i_start_pos,
    input  smbtp_pkg::t_sword   i_end_pos,
    input  smbtp_pkg::t_sword   i_start_vel,
    input  smbtp_pkg::t_sword   i_end_vel,
    input  smbtp_pkg::t_uword31 i_duration,
    input  smbtp_pkg::t_sword   i_query_time,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  smbtp_pkg::t_uword31 i_cfg_blend_alpha,
    output logic                o_valid,
    output smbtp_pkg::t_sword   o_position
);
    import smbtp_pkg::*;

    localparam t_sword ONE       = t_sword'(64'd1 << FRAC_BITS);
    localparam t_sword FLOOR_NUM = t_sword'(64'd1 << MIN_SPEED_SHIFT);
    localparam int     OUT_LAT   = 2 * DIV_LAT + 12;

    typedef struct packed {
        logic     v;
        t_sword   a;
        t_sword   b;
        t_sword   av;
        t_sword   bv;
        t_uword31 tf;
        t_sword   t;
        t_sword   tmt;
        t_sword   tft;
    } t_d1;

    typedef struct packed {
        logic     v;
        t_sword   l;
        t_sword   r;
        t_sword   m;
        t_sword   s2;
        t_sword   t;
        t_uword31 tf;
    } t_d2;

    typedef struct packed {
        logic   v;
        t_sword l;
        t_sword r;
        t_sword m;
        t_sword s2;
        t_sword t;
        logic   ca;
        logic   ce;
    } t_q;

    function automatic t_uword31 clamp_speed(t_sword vel, t_sword fl);
        t_sword sp;
        sp = vel[31] ? -vel : vel;
        if (sp < fl) sp = fl;
        if (sp < 32'sd1) sp = 32'sd1;
        return sp[30:0];
    endfunction

    // configuration
    t_uword31 r_alpha;
    t_uword31 w_alpha;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha <= ALPHA_RESET;
        end else if (i_cfg_valid) begin
            r_alpha <= i_cfg_blend_alpha;
        end
    end

    assign w_alpha     = (r_alpha == '0) ? 31'd1 : r_alpha;
    assign o_cfg_ready = 1'b1;
    assign busy        = 1'b0;

    // stage 1: capture
    t_d1 r_s1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.v <= 1'b0;
        end else begin
            r_s1.v   <= start & ~busy;
            r_s1.a   <= i_start_pos;
            r_s1.b   <= i_end_pos;
            r_s1.av  <= i_start_vel;
            r_s1.bv  <= i_end_vel;
            r_s1.tf  <= (i_duration == '0) ? 31'd1 : i_duration;
            r_s1.t   <= i_query_time;
            r_s1.tmt <= '0;
            r_s1.tft <= '0;
        end
    end

    // stage 2: chord product and offsets
    t_d1    r_s2;
    t_d1    n_s2;
    t_sword r_s2_dm;
    t_sword r_s2_ts;

    always_comb begin
        n_s2     = r_s1;
        n_s2.tmt = r_s1.t - $signed({1'b0, r_s1.tf});
        n_s2.tft = $signed({1'b0, r_s1.tf}) - r_s1.t;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2.v <= 1'b0;
        end else begin
            r_s2     <= n_s2;
            r_s2_dm  <= (r_s1.b - r_s1.a) * r_s1.t;
            r_s2_ts  <= r_s1.t <<< FRAC_BITS;
        end
    end

    t_sword w_qm, w_qs2, w_qfl;
    smbtp_div u_div_m  (.i_clk(i_clk), .i_num(r_s2_dm),   .i_den(r_s2.tf), .o_quo(w_qm));
    smbtp_div u_div_s2 (.i_clk(i_clk), .i_num(r_s2_ts),   .i_den(r_s2.tf), .o_quo(w_qs2));
    smbtp_div u_div_fl (.i_clk(i_clk), .i_num(FLOOR_NUM), .i_den(r_s2.tf), .o_quo(w_qfl));

    t_d1 r_d1 [0:DIV_LAT-1];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DIV_LAT; k++) r_d1[k].v <= 1'b0;
        end else begin
            r_d1[0] <= r_s2;
            for (int k = 1; k < DIV_LAT; k++) r_d1[k] <= r_d1[k-1];
        end
    end

    t_d1 w_p;
    assign w_p = r_d1[DIV_LAT-1];

    // p1: chord, speeds, tangent products
    logic     r_p1_v;
    t_sword   r_p1_a, r_p1_b, r_p1_t, r_p1_tft, r_p1_m, r_p1_s2, r_p1_lp, r_p1_rp;
    t_uword31 r_p1_tf, r_p1_avc, r_p1_bvc;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_v <= 1'b0;
        end else begin
            r_p1_v   <= w_p.v;
            r_p1_a   <= w_p.a;
            r_p1_b   <= w_p.b;
            r_p1_t   <= w_p.t;
            r_p1_tft <= w_p.tft;
            r_p1_tf  <= w_p.tf;
            r_p1_m   <= w_qm + w_p.a;
            r_p1_s2  <= w_qs2;
            r_p1_avc <= clamp_speed(w_p.av, w_qfl);
            r_p1_bvc <= clamp_speed(w_p.bv, w_qfl);
            r_p1_lp  <= w_p.av * w_p.t;
            r_p1_rp  <= w_p.bv * w_p.tmt;
        end
    end

    // p2: tangent lines, window dividends and smoothstep argument dividends
    logic     r_p2_v;
    t_sword   r_p2_l, r_p2_r, r_p2_m, r_p2_s2, r_p2_t, r_p2_alsh, r_p2_pa, r_p2_pb;
    t_uword31 r_p2_tf, r_p2_av, r_p2_bv;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p2_v <= 1'b0;
        end else begin
            r_p2_v    <= r_p1_v;
            r_p2_l    <= (r_p1_lp >>> FRAC_BITS) + r_p1_a;
            r_p2_r    <= (r_p1_rp >>> FRAC_BITS) + r_p1_b;
            r_p2_m    <= r_p1_m;
            r_p2_s2   <= r_p1_s2;
            r_p2_t    <= r_p1_t;
            r_p2_tf   <= r_p1_tf;
            r_p2_alsh <= t_sword'({1'b0, w_alpha} << FRAC_BITS);
            r_p2_pa   <= r_p1_t * $signed({1'b0, r_p1_avc});
            r_p2_pb   <= r_p1_tft * $signed({1'b0, r_p1_bvc});
            r_p2_av   <= r_p1_avc;
            r_p2_bv   <= r_p1_bvc;
        end
    end

    t_sword w_wa, w_wb, w_x0, w_x1;
    smbtp_div u_div_wa (.i_clk(i_clk), .i_num(r_p2_alsh), .i_den(r_p2_av), .o_quo(w_wa));
    smbtp_div u_div_wb (.i_clk(i_clk), .i_num(r_p2_alsh), .i_den(r_p2_bv), .o_quo(w_wb));
    smbtp_div u_div_x0 (.i_clk(i_clk), .i_num(r_p2_pa),   .i_den(w_alpha), .o_quo(w_x0));
    smbtp_div u_div_x1 (.i_clk(i_clk), .i_num(r_p2_pb),   .i_den(w_alpha), .o_quo(w_x1));

    t_d2 r_d2 [0:DIV_LAT-1];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DIV_LAT; k++) r_d2[k].v <= 1'b0;
        end else begin
            r_d2[0].v  <= r_p2_v;
            r_d2[0].l  <= r_p2_l;
            r_d2[0].r  <= r_p2_r;
            r_d2[0].m  <= r_p2_m;
            r_d2[0].s2 <= r_p2_s2;
            r_d2[0].t  <= r_p2_t;
            r_d2[0].tf <= r_p2_tf;
            for (int k = 1; k < DIV_LAT; k++) r_d2[k] <= r_d2[k-1];
        end
    end

    t_d2 w_e;
    assign w_e = r_d2[DIV_LAT-1];

    // blend stages
    t_q     r_q [1:7];
    t_q     n_q2;
    t_sword r_q1_edge, r_q1_wa, r_q1_x0, r_q1_x1, r_q1_sq0, r_q1_sq1;
    t_sword r_q2_x0, r_q2_x1, r_q2_x20, r_q2_x21;
    t_sword r_q3_x20, r_q3_x21, r_q3_p30, r_q3_p31;
    t_sword r_q4_s0, r_q4_s1;
    t_sword r_q5_ul, r_q5_vl, r_q5_ur, r_q5_vr;
    t_sword r_q6_bl, r_q6_br;
    t_sword r_q7_bl, r_q7_br, r_q7_pl, r_q7_pr;

    always_comb begin
        n_q2    = r_q[1];
        n_q2.ca = r_q[1].t < r_q1_wa;
        n_q2.ce = r_q[1].t >= r_q1_edge;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 1; k <= 7; k++) r_q[k].v <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r_q[1].v  <= w_e.v;
            r_q[1].l  <= w_e.l;
            r_q[1].r  <= w_e.r;
            r_q[1].m  <= w_e.m;
            r_q[1].s2 <= w_e.s2;
            r_q[1].t  <= w_e.t;
            r_q[1].ca <= 1'b0;
            r_q[1].ce <= 1'b0;
            r_q1_edge <= $signed({1'b0, w_e.tf}) - w_wb;
            r_q1_wa   <= w_wa;
            r_q1_x0   <= w_x0;
            r_q1_x1   <= w_x1;
            r_q1_sq0  <= w_x0 * w_x0;
            r_q1_sq1  <= w_x1 * w_x1;

            r_q[2]    <= n_q2;
            r_q2_x0   <= r_q1_x0;
            r_q2_x1   <= r_q1_x1;
            r_q2_x20  <= r_q1_sq0 >>> FRAC_BITS;
            r_q2_x21  <= r_q1_sq1 >>> FRAC_BITS;

            r_q[3]   <= r_q[2];
            r_q3_x20 <= r_q2_x20;
            r_q3_x21 <= r_q2_x21;
            r_q3_p30 <= r_q2_x20 * r_q2_x0;
            r_q3_p31 <= r_q2_x21 * r_q2_x1;

            // smoothstep 3x^2 - 2x^3
            r_q[4]  <= r_q[3];
            r_q4_s0 <= ((r_q3_x20 <<< 1) + r_q3_x20) - ((r_q3_p30 >>> FRAC_BITS) <<< 1);
            r_q4_s1 <= ((r_q3_x21 <<< 1) + r_q3_x21) - ((r_q3_p31 >>> FRAC_BITS) <<< 1);

            r_q[5]  <= r_q[4];
            r_q5_ul <= r_q[4].l * (ONE - r_q4_s0);
            r_q5_vl <= r_q[4].m * r_q4_s0;
            r_q5_ur <= r_q[4].r * (ONE - r_q4_s1);
            r_q5_vr <= r_q[4].m * r_q4_s1;

            r_q[6]  <= r_q[5];
            r_q6_bl <= (r_q5_ul + r_q5_vl) >>> FRAC_BITS;
            r_q6_br <= (r_q5_ur + r_q5_vr) >>> FRAC_BITS;

            r_q[7]  <= r_q[6];
            r_q7_bl <= r_q6_bl;
            r_q7_br <= r_q6_br;
            r_q7_pl <= r_q6_bl * (ONE - r_q[6].s2);
            r_q7_pr <= r_q6_br * r_q[6].s2;

            o_valid <= r_q[7].v;
            if (r_q[7].ca && r_q[7].ce) begin
                o_position <= (r_q7_pl >>> FRAC_BITS) + (r_q7_pr >>> FRAC_BITS);
            end else if (r_q[7].ca) begin
                o_position <= r_q7_bl;
            end else if (!r_q[7].ce) begin
                o_position <= r_q[7].m;
            end else begin
                o_position <= r_q7_br;
            end
        end
    end

    a_lat_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |-> ##OUT_LAT o_valid)
        else $error("result missing after start");

    a_lat_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, OUT_LAT))
        else $error("result without matching start");

    a_tf_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2.v |-> r_s2.tf != '0)
        else $error("zero duration reached divider");

    a_speed_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p2_v |-> (r_p2_av != '0) && (r_p2_bv != '0))
        else $error("zero speed reached divider");

endmodule
